// ===== hdl/rsi_pkg.sv =====
package rsi_pkg;

  // Angle constants in Q.40.
  localparam logic signed [49:0] PiQ40     = 50'sd3454217652358;
  localparam logic signed [49:0] TwoPiQ40  = 50'sd6908435304716;
  localparam logic signed [49:0] HalfPiQ40 = 50'sd1727108826179;

  // CORDIC setup: gain-compensated start value and the number of rotations.
  localparam logic signed [33:0] CordicGain  = 34'sd652032874;
  localparam int                 CordicSteps = 30;

  // Range reduction subtracts 2*pi shifted left by one place less than this, down to zero.
  localparam int ModSteps = 6;

  // Serial multiplier and divider lengths in steps.
  localparam int MulSteps = 40;
  localparam int DivSteps = 49;

  // Saturation limits of an estimate in Q16.32.
  localparam logic signed [52:0] EstMax = 53'sd140737488355327;
  localparam logic signed [52:0] EstMin = -53'sd140737488355328;

  // Arctangent of 2^-i in Q.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] val;
    case (idx)
      5'd0:    val = 30'd843314857;
      5'd1:    val = 30'd497837829;
      5'd2:    val = 30'd263043837;
      5'd3:    val = 30'd133525159;
      5'd4:    val = 30'd67021687;
      5'd5:    val = 30'd33543516;
      5'd6:    val = 30'd16775851;
      5'd7:    val = 30'd8388437;
      5'd8:    val = 30'd4194283;
      5'd9:    val = 30'd2097149;
      5'd10:   val = 30'd1048576;
      5'd11:   val = 30'd524288;
      5'd12:   val = 30'd262144;
      5'd13:   val = 30'd131072;
      5'd14:   val = 30'd65536;
      5'd15:   val = 30'd32768;
      5'd16:   val = 30'd16384;
      5'd17:   val = 30'd8192;
      5'd18:   val = 30'd4096;
      5'd19:   val = 30'd2048;
      5'd20:   val = 30'd1024;
      5'd21:   val = 30'd512;
      5'd22:   val = 30'd256;
      5'd23:   val = 30'd128;
      5'd24:   val = 30'd64;
      5'd25:   val = 30'd32;
      5'd26:   val = 30'd16;
      5'd27:   val = 30'd8;
      5'd28:   val = 30'd4;
      5'd29:   val = 30'd2;
      default: val = 30'd0;
    endcase
    return val;
  endfunction

  // Clip a wide signed value to the 48-bit estimate range.
  function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
    logic signed [47:0] res;
    if (v > EstMax) begin
      res = EstMax[47:0];
    end else if (v < EstMin) begin
      res = EstMin[47:0];
    end else begin
      res = v[47:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/romberg_sine_integrator_unit.sv =====
// Romberg tableau of the integral of sin over [a,b], one shared datapath under a sequencer.
// Each sine takes 6 reduction steps, 30 CORDIC rotations and bookkeeping states. Row n
// samples its 2^(n-1) midpoints (row 0 the two endpoints), then a serial multiply gives
// column 0 and each extrapolated column goes through a 49-step divider. busy is high from
// the cycle after acceptance until the last result shows on valid_o, when it is low again,
// so the next request can be taken in the same cycle as the last result is shown.
// Reset is asynchronous, active low, and sets levels to 4; results cannot be stalled.
module romberg_sine_integrator_unit #(
  parameter int MAX_LEVELS = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] lower_bound_i,
  input  logic signed [31:0] upper_bound_i,
  output logic               valid_o,
  output logic [3:0]         row_index_o,
  output logic [3:0]         column_index_o,
  output logic signed [47:0] estimate_o,
  output logic               last_o
);

  localparam int Rows = MAX_LEVELS + 1;
  localparam int IdxW = (Rows > 1) ? $clog2(Rows) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MOD, ST_FOLD1, ST_FOLD2, ST_FOLD3, ST_ZINIT, ST_ROT,
    ST_ACC, ST_MULI, ST_MUL, ST_SCALE, ST_EST0, ST_DIFF, ST_DIV, ST_ESTM
  } state_e;

  state_e state_q;

  logic [3:0]         levels_q;
  logic signed [31:0] lb_q;
  logic signed [31:0] ub_q;
  logic signed [32:0] diff_q;
  logic signed [51:0] ang_q;
  logic signed [51:0] step2_q;
  logic [48:0]        rem_q;
  logic               angneg_q;
  logic signed [49:0] r_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [5:0]         it_q;
  logic [8:0]         mcnt_q;
  logic signed [39:0] sum_q;
  logic               first_q;
  logic [32:0]        amag_q;
  logic [73:0]        prod_q;
  logic               pneg_q;
  logic signed [51:0] t_q;
  logic signed [47:0] last_est_q;
  logic [48:0]        quo_q;
  logic [17:0]        drem_q;
  logic [17:0]        dvs_q;
  logic               dneg_q;
  logic [3:0]         n_q, m_q, lv_q;
  logic               bank_q;

  // Two banks of tableau rows; one holds the previous row, the other the current one.
  logic signed [47:0] row_mem [2][Rows];

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {28'd0, levels_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= 4'd4;
    end else if (psel && penable && pwrite && pready) begin
      levels_q <= pwdata[3:0];
    end
  end

  // Previous-row read port.
  logic [3:0]         rd_idx;
  logic signed [47:0] prev_rd;
  assign rd_idx  = (state_q == ST_DIFF) ? (m_q - 4'd1) : 4'd0;
  assign prev_rd = row_mem[!bank_q][rd_idx[IdxW-1:0]];

  // Reduction compare against 2*pi shifted.
  logic [48:0] mod_cmp;
  assign mod_cmp = 49'(rsi_pkg::TwoPiQ40) << it_q;

  // Folding and angle scaling.
  logic [49:0]        r_mag;
  logic [49:0]        z_mag;
  assign r_mag = r_q[49] ? 50'(-r_q) : 50'(r_q);
  assign z_mag = r_mag >> 10;

  // CORDIC rotation terms.
  logic signed [33:0] dx, dy, atan_s;
  assign dx     = y_q >>> it_q[4:0];
  assign dy     = x_q >>> it_q[4:0];
  assign atan_s = $signed({4'd0, rsi_pkg::atan_q30(it_q[4:0])});

  // Multiplier step: conditional add into the upper half, shift right.
  logic [34:0] mul_add;
  assign mul_add = 35'(prod_q[73:40]) + (prod_q[0] ? 35'(amag_q) : 35'd0);

  // Product scaling: row 0 drops 23 bits, row n drops 22+n.
  logic [4:0]  sh_amt;
  logic [73:0] prod_sh;
  assign sh_amt  = (n_q == 4'd0) ? 5'd23 : 5'd22 + 5'(n_q);
  assign prod_sh = prod_q >> sh_amt;

  // Divider step.
  logic [18:0] div_sh;
  logic        div_ge;
  assign div_sh = {drem_q, quo_q[48]};
  assign div_ge = div_sh >= {1'b0, dvs_q};

  // First-column estimate: half of the previous entry (toward zero) plus h*sum; row 0 uses h*sum alone.
  logic signed [48:0] prev_half;
  logic signed [47:0] est0;
  assign prev_half = $signed(49'(prev_rd) + 49'(prev_rd < 0)) >>> 1;
  assign est0 = (n_q == 4'd0) ? rsi_pkg::sat48(53'(t_q))
                              : rsi_pkg::sat48(53'(prev_half) + 53'(t_q));

  // Extrapolated estimate and the difference that feeds it.
  logic signed [52:0] quot_s;
  logic signed [47:0] estm;
  logic signed [48:0] dval;
  assign quot_s = dneg_q ? -$signed(53'(quo_q)) : $signed(53'(quo_q));
  assign estm   = rsi_pkg::sat48(53'(last_est_q) + quot_s);
  assign dval   = 49'(last_est_q) - 49'(prev_rd);

  logic emit_now;
  logic signed [47:0] emit_est;
  assign emit_now = (state_q == ST_EST0) || (state_q == ST_ESTM);
  assign emit_est = (state_q == ST_EST0) ? est0 : estm;

  assign busy = (state_q != ST_IDLE);

  // Row storage writes.
  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      row_mem[bank_q][m_q[IdxW-1:0]] <= emit_est;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      lb_q           <= '0;
      ub_q           <= '0;
      diff_q         <= '0;
      ang_q          <= '0;
      step2_q        <= '0;
      rem_q          <= '0;
      angneg_q       <= 1'b0;
      r_q            <= '0;
      x_q            <= '0;
      y_q            <= '0;
      z_q            <= '0;
      it_q           <= '0;
      mcnt_q         <= '0;
      sum_q          <= '0;
      first_q        <= 1'b0;
      amag_q         <= '0;
      prod_q         <= '0;
      pneg_q         <= 1'b0;
      t_q            <= '0;
      last_est_q     <= '0;
      quo_q          <= '0;
      drem_q         <= '0;
      dvs_q          <= '0;
      dneg_q         <= 1'b0;
      n_q            <= '0;
      m_q            <= '0;
      lv_q           <= '0;
      bank_q         <= 1'b0;
      valid_o        <= 1'b0;
      row_index_o    <= '0;
      column_index_o <= '0;
      estimate_o     <= '0;
      last_o         <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            lb_q    <= lower_bound_i;
            ub_q    <= upper_bound_i;
            diff_q  <= 33'(upper_bound_i) - 33'(lower_bound_i);
            ang_q   <= 52'(lower_bound_i) <<< 16;
            sum_q   <= '0;
            first_q <= 1'b1;
            n_q     <= '0;
            m_q     <= '0;
            lv_q    <= (levels_q > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : levels_q;
            state_q <= ST_SETUP;
          end
        end

        ST_SETUP: begin
          angneg_q <= ang_q[51];
          rem_q    <= ang_q[51] ? 49'(-ang_q) : 49'(ang_q);
          it_q     <= 6'(rsi_pkg::ModSteps - 1);
          state_q  <= ST_MOD;
        end

        // Remainder modulo 2*pi of the angle magnitude.
        ST_MOD: begin
          if (rem_q >= mod_cmp) begin
            rem_q <= rem_q - mod_cmp;
          end
          if (it_q == 6'd0) begin
            state_q <= ST_FOLD1;
          end else begin
            it_q <= it_q - 6'd1;
          end
        end

        ST_FOLD1: begin
          r_q     <= angneg_q ? rsi_pkg::TwoPiQ40 - $signed(50'(rem_q)) : $signed(50'(rem_q));
          state_q <= ST_FOLD2;
        end

        ST_FOLD2: begin
          if (r_q > rsi_pkg::PiQ40) begin
            r_q <= r_q - rsi_pkg::TwoPiQ40;
          end
          state_q <= ST_FOLD3;
        end

        ST_FOLD3: begin
          if (r_q > rsi_pkg::HalfPiQ40) begin
            r_q <= rsi_pkg::PiQ40 - r_q;
          end else if (r_q < -rsi_pkg::HalfPiQ40) begin
            r_q <= -rsi_pkg::PiQ40 - r_q;
          end
          state_q <= ST_ZINIT;
        end

        ST_ZINIT: begin
          z_q     <= r_q[49] ? -$signed(34'(z_mag)) : $signed(34'(z_mag));
          x_q     <= rsi_pkg::CordicGain;
          y_q     <= '0;
          it_q    <= '0;
          state_q <= ST_ROT;
        end

        ST_ROT: begin
          if (!z_q[33]) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - atan_s;
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + atan_s;
          end
          if (it_q == 6'(rsi_pkg::CordicSteps - 1)) begin
            state_q <= ST_ACC;
          end else begin
            it_q <= it_q + 6'd1;
          end
        end

        // Accumulate the sample and pick the next one.
        ST_ACC: begin
          sum_q <= sum_q + 40'(y_q);
          if (n_q == 4'd0) begin
            if (first_q) begin
              first_q <= 1'b0;
              ang_q   <= 52'(ub_q) <<< 16;
              state_q <= ST_SETUP;
            end else begin
              state_q <= ST_MULI;
            end
          end else if (mcnt_q == 9'd1) begin
            state_q <= ST_MULI;
          end else begin
            mcnt_q  <= mcnt_q - 9'd1;
            ang_q   <= ang_q + step2_q;
            state_q <= ST_SETUP;
          end
        end

        ST_MULI: begin
          amag_q  <= diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
          prod_q  <= {34'd0, (sum_q[39] ? 40'(-sum_q) : 40'(sum_q))};
          pneg_q  <= diff_q[32] ^ sum_q[39];
          it_q    <= '0;
          state_q <= ST_MUL;
        end

        ST_MUL: begin
          prod_q <= {mul_add, prod_q[39:1]};
          if (it_q == 6'(rsi_pkg::MulSteps - 1)) begin
            state_q <= ST_SCALE;
          end else begin
            it_q <= it_q + 6'd1;
          end
        end

        ST_SCALE: begin
          t_q     <= pneg_q ? -$signed(prod_sh[51:0]) : $signed(prod_sh[51:0]);
          state_q <= ST_EST0;
        end

        ST_DIFF: begin
          dneg_q  <= dval[48];
          quo_q   <= dval[48] ? 49'(-dval) : 49'(dval);
          drem_q  <= '0;
          dvs_q   <= 18'((36'd1 << (2 * m_q)) - 36'd1);
          it_q    <= '0;
          state_q <= ST_DIV;
        end

        // Restoring division by 4^m-1, one quotient bit per cycle.
        ST_DIV: begin
          if (div_ge) begin
            drem_q <= 18'(div_sh - {1'b0, dvs_q});
          end else begin
            drem_q <= div_sh[17:0];
          end
          quo_q <= {quo_q[47:0], div_ge};
          if (it_q == 6'(rsi_pkg::DivSteps - 1)) begin
            state_q <= ST_ESTM;
          end else begin
            it_q <= it_q + 6'd1;
          end
        end

        // Emit an entry, then move to the next column, the next row or finish.
        ST_EST0, ST_ESTM: begin
          valid_o        <= 1'b1;
          row_index_o    <= n_q;
          column_index_o <= m_q;
          estimate_o     <= emit_est;
          last_o         <= (n_q == lv_q) && (m_q == n_q);
          last_est_q     <= emit_est;
          if (m_q == n_q) begin
            if (n_q == lv_q) begin
              state_q <= ST_IDLE;
            end else begin
              n_q     <= n_q + 4'd1;
              m_q     <= '0;
              bank_q  <= !bank_q;
              ang_q   <= (52'(lb_q) <<< 16) + (52'(diff_q) <<< (5'd15 - 5'(n_q)));
              step2_q <= 52'(diff_q) <<< (5'd16 - 5'(n_q));
              mcnt_q  <= 9'd1 << n_q;
              sum_q   <= '0;
              state_q <= ST_SETUP;
            end
          end else begin
            m_q     <= m_q + 4'd1;
            state_q <= ST_DIFF;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
